@@ rtl/core/kms_pkg.sv @@
// Shared types and constants for the keypad matrix scanner.
package kms_pkg;

    localparam int NUM_COLUMNS = 4;
    localparam int NUM_ROWS    = 4;

    localparam int COL_W      = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROW_IDX_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int TIME_W     = 16;
    localparam int SENSE_W    = 4;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [TIME_W-1:0] DEBOUNCE_RST     = TIME_W'(40);
    localparam logic [TIME_W-1:0] RELEASE_POLL_RST = TIME_W'(100);
    localparam logic [TIME_W-1:0] REPEAT_DELAY_RST = TIME_W'(500);
    localparam logic [TIME_W-1:0] REPEAT_PERIOD_RST = TIME_W'(100);

    typedef logic [NUM_ROWS-1:0]  rows_t;
    typedef logic [COL_W-1:0]     col_idx_t;
    typedef logic [ROW_IDX_W-1:0] row_idx_t;
    typedef logic [TIME_W-1:0]    ticks_t;

    typedef enum logic [1:0]
    {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_DEBOUNCE      = 2'd0,
        REG_RELEASE_POLL  = 2'd1,
        REG_REPEAT_DELAY  = 2'd2,
        REG_REPEAT_PERIOD = 2'd3
    } cfg_reg_t;

    function automatic ticks_t sat_inc(input ticks_t v);
        return (v != TIME_MAX) ? ticks_t'(v + 1'b1) : TIME_MAX;
    endfunction

endpackage

@@ rtl/core/keypad_matrix_scanner.sv @@
// Keypad matrix scanner top level: debounce, release poll and auto-repeat.
//
// One item is one millisecond tick carrying the active-low row sense for the column that
// the previous result drove low; every item yields exactly one result with the next
// column_drive and an optional key event (key_code = column * rows + row, key_down 1 for
// press or repeat, 0 for release). Outside a key action the columns are walked one per tick;
// a non-idle row pattern holds the column for debounce_ticks, after which the rows must
// match and show exactly one low row to report a press. The held key is then polled every
// release_poll_ticks for release, with repeats once repeat_delay_ticks have passed and more
// than repeat_period_ticks separate events. Time counters saturate at 65535. Throughput is
// one item per clock while the result is not stalled: the item sits in an input register,
// one short pass of compare and increment logic updates the scan state and loads the
// result register; each item passes through the input register and then the result register.
// in_stall rises only when both registers are full and the result is stalled. Configuration
// writes are always taken (cfg_ready is high) and should be made while no item is in flight.
module keypad_matrix_scanner
    import kms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SENSE_W-1:0]   row_sense,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SENSE_W-1:0]   column_drive,
    output logic                 event_valid,
    output logic [CODE_W-1:0]    key_code,
    output logic                 key_down,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    localparam rows_t ROW_MASK = '1;

    // config registers
    ticks_t debounce_reg;
    ticks_t release_poll_reg;
    ticks_t repeat_delay_reg;
    ticks_t repeat_period_reg;

    // input stage
    logic  in_valid_reg;
    rows_t rows_reg;

    // scan state
    phase_t     phase_reg, phase_next;
    col_idx_t   col_reg, col_next;
    rows_t      latched_reg, latched_next;
    ticks_t     wait_reg, wait_next;
    ticks_t     held_reg, held_next;
    ticks_t     since_reg, since_next;
    logic       pressed_reg, pressed_next;
    logic [CODE_W-1:0] key_reg, key_next;

    // result stage
    logic               out_valid_reg;
    logic [SENSE_W-1:0] drive_reg, drive_next;
    logic               ev_reg, ev_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               down_reg, down_next;

    logic out_free;
    logic advance;

    // Result register is free when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign column_drive = drive_reg;
    assign event_valid  = ev_reg;
    assign key_code     = code_reg;
    assign key_down     = down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RST;
            release_poll_reg  <= RELEASE_POLL_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE:      debounce_reg      <= cfg_data;
                REG_RELEASE_POLL:  release_poll_reg  <= cfg_data;
                REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                REG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register: loads whenever it is empty or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            rows_reg <= rows_t'(row_sense);
        end
    end

    // Main tick update.
    always_comb
    begin
        rows_t    low;
        logic     one_low;
        row_idx_t row_idx;
        logic [7:0] code_wide;
        logic [7:0] col_sel;

        phase_next   = phase_reg;
        col_next     = col_reg;
        latched_next = latched_reg;
        wait_next    = wait_reg;
        held_next    = held_reg;
        since_next   = since_reg;
        pressed_next = pressed_reg;
        key_next     = key_reg;
        ev_next      = 1'b0;
        code_next    = '0;
        down_next    = 1'b0;

        low     = ~rows_reg;
        one_low = (low != '0) && ((low & rows_t'(low - 1'b1)) == '0);
        row_idx = '0;
        for (int r = NUM_ROWS - 1; r >= 0; r--)
        begin
            if (low[r])
            begin
                row_idx = row_idx_t'(r);
            end
        end
        code_wide = 8'(8'(col_reg) * 8'(NUM_ROWS)) + 8'(row_idx);

        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                wait_next = sat_inc(wait_reg);
                if (wait_next >= debounce_reg)
                begin
                    pressed_next = 1'b0;
                    if (rows_reg == latched_reg && one_low)
                    begin
                        key_next     = code_wide[CODE_W-1:0];
                        pressed_next = 1'b1;
                        ev_next      = 1'b1;
                        code_next    = code_wide[CODE_W-1:0];
                        down_next    = 1'b1;
                    end
                    phase_next = PH_HOLD;
                    wait_next  = '0;
                    held_next  = '0;
                    since_next = '0;
                end
            end
            PH_HOLD:
            begin
                wait_next  = sat_inc(wait_reg);
                held_next  = sat_inc(held_reg);
                since_next = sat_inc(since_reg);
                if (wait_next >= release_poll_reg)
                begin
                    wait_next = '0;
                    if (rows_reg == ROW_MASK)
                    begin
                        // release; key-up only if a press was reported
                        if (pressed_reg)
                        begin
                            ev_next      = 1'b1;
                            code_next    = key_reg;
                            pressed_next = 1'b0;
                        end
                        phase_next   = PH_SCAN;
                        col_next     = '0;
                        latched_next = ROW_MASK;
                    end
                    else if (held_next >= repeat_delay_reg && pressed_reg &&
                             since_next > repeat_period_reg)
                    begin
                        ev_next    = 1'b1;
                        code_next  = key_reg;
                        down_next  = 1'b1;
                        since_next = '0;
                    end
                end
            end
            default:
            begin
                // scanning, also any unused phase code
                phase_next = PH_SCAN;
                if (rows_reg != ROW_MASK)
                begin
                    latched_next = rows_reg;
                    wait_next    = '0;
                    phase_next   = PH_DEBOUNCE;
                end
                else if (col_reg == col_idx_t'(NUM_COLUMNS - 1))
                begin
                    col_next = '0;
                end
                else
                begin
                    col_next = col_idx_t'(col_reg + 1'b1);
                end
            end
        endcase

        col_sel    = 8'd1 << col_next;
        drive_next = ~col_sel[SENSE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SCAN;
            col_reg     <= '0;
            latched_reg <= ROW_MASK;
            wait_reg    <= '0;
            held_reg    <= '0;
            since_reg   <= '0;
            pressed_reg <= 1'b0;
            key_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            col_reg     <= col_next;
            latched_reg <= latched_next;
            wait_reg    <= wait_next;
            held_reg    <= held_next;
            since_reg   <= since_next;
            pressed_reg <= pressed_next;
            key_reg     <= key_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
            ev_reg    <= ev_next;
            code_reg  <= code_next;
            down_reg  <= down_next;
        end
    end

endmodule
